>>> rtl/core/vrp_pkg.sv
//------------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the vertex rotate/project block.
//------------------------------------------------------------------------------
package vrp_pkg;

	localparam int FracBitsDefault = 16;
	localparam int NumRegs = 8;
	localparam int AddrW = 5;

	localparam logic [AddrW-1:0] RegCos  = 5'd0;
	localparam logic [AddrW-1:0] RegSin  = 5'd4;
	localparam logic [AddrW-1:0] RegAx   = 5'd8;
	localparam logic [AddrW-1:0] RegAy   = 5'd12;
	localparam logic [AddrW-1:0] RegQ    = 5'd16;
	localparam logic [AddrW-1:0] RegBias = 5'd20;
	localparam logic [AddrW-1:0] RegSx   = 5'd24;
	localparam logic [AddrW-1:0] RegSy   = 5'd28;

	typedef struct packed {
		logic signed [17:0] cos_angle;
		logic signed [17:0] sin_angle;
		logic [30:0] x_proj_scale;
		logic [30:0] y_proj_scale;
		logic [30:0] depth_scale;
		logic signed [31:0] depth_bias;
		logic [30:0] screen_x_scale;
		logic [30:0] screen_y_scale;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
	} vert_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth_out;
		logic w_zero;
	} pix_t;

	// projected item handed from the front to the back
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] w;
	} proj_t;

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > 96'sd2147483647) return 32'sh7fffffff;
		if (v < -96'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

>>> rtl/core/vrp_if.sv
//------------------------------------------------------------------------------
// vrp_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
interface vrp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/vrp_front.sv
//------------------------------------------------------------------------------
// vrp_front
// Rotation and projection pipeline, one vertex per cycle, stall by enable.
//------------------------------------------------------------------------------
module vrp_front #(
	parameter int FRAC_BITS = vrp_pkg::FracBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  vrp_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  vrp_pkg::vert_t vin,
	output logic out_valid,
	input  logic out_ready,
	output vrp_pkg::proj_t pout
);
	localparam int NS = 6;
	logic [NS-1:0] v_q;
	logic adv;
	assign adv = !v_q[NS-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_q[NS-1];

	logic signed [49:0] cx_s1, sy_s1, sx_s1, cy_s1;
	logic signed [31:0] z_s1, z_s2;
	logic signed [31:0] x1_s2, y1_s2, x1_s3, x1_s4;
	logic signed [49:0] cy_s3, sz_s3, sy_s3, cz_s3;
	logic signed [31:0] y2_s4, z2_s4;
	logic signed [62:0] px_s5, py_s5, pz_s5;
	logic signed [31:0] w_s5;
	logic signed [31:0] px_s6, py_s6, pz_s6, w_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= cfg.cos_angle * vin.vert_x;
			sy_s1 <= cfg.sin_angle * vin.vert_y;
			sx_s1 <= cfg.sin_angle * vin.vert_x;
			cy_s1 <= cfg.cos_angle * vin.vert_y;
			z_s1 <= vin.vert_z;
			x1_s2 <= vrp_pkg::sat32(96'(($signed(51'(cx_s1)) - sy_s1) >>> FRAC_BITS));
			y1_s2 <= vrp_pkg::sat32(96'(($signed(51'(sx_s1)) + cy_s1) >>> FRAC_BITS));
			z_s2 <= z_s1;
			cy_s3 <= cfg.cos_angle * y1_s2;
			sz_s3 <= cfg.sin_angle * z_s2;
			sy_s3 <= cfg.sin_angle * y1_s2;
			cz_s3 <= cfg.cos_angle * z_s2;
			x1_s3 <= x1_s2;
			y2_s4 <= vrp_pkg::sat32(96'(($signed(51'(cy_s3)) - sz_s3) >>> FRAC_BITS));
			z2_s4 <= vrp_pkg::sat32(96'(vrp_pkg::sat32(96'(($signed(51'(sy_s3)) + cz_s3)
				>>> FRAC_BITS))) + (96'sd3 <<< FRAC_BITS));
			x1_s4 <= x1_s3;
			px_s5 <= $signed({1'b0, cfg.x_proj_scale}) * x1_s4;
			py_s5 <= $signed({1'b0, cfg.y_proj_scale}) * y2_s4;
			pz_s5 <= $signed({1'b0, cfg.depth_scale}) * z2_s4;
			w_s5 <= z2_s4;
			px_s6 <= vrp_pkg::sat32(96'(px_s5 >>> FRAC_BITS));
			py_s6 <= vrp_pkg::sat32(96'(py_s5 >>> FRAC_BITS));
			pz_s6 <= vrp_pkg::sat32(96'(pz_s5 >>> FRAC_BITS) + 96'(cfg.depth_bias));
			w_s6 <= w_s5;
		end
	end

	assign pout = '{px: px_s6, py: py_s6, pz: pz_s6, w: w_s6};
endmodule

>>> rtl/core/vrp_queue.sv
//------------------------------------------------------------------------------
// vrp_queue
// Two-entry queue between front and back.
//------------------------------------------------------------------------------
module vrp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  vrp_pkg::proj_t din,
	output logic out_valid,
	input  logic out_ready,
	output vrp_pkg::proj_t dout
);
	vrp_pkg::proj_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;
	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= din;
	end
endmodule

>>> rtl/core/vrp_back.sv
//------------------------------------------------------------------------------
// vrp_back
// Pipelined radix-2 divider for three quotients, then screen mapping.
//------------------------------------------------------------------------------
module vrp_back #(
	parameter int FRAC_BITS = vrp_pkg::FracBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  vrp_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  vrp_pkg::proj_t pin,
	output logic out_valid,
	input  logic out_ready,
	output vrp_pkg::pix_t pout
);
	// numerator |p|<<F fits in NW bits; one quotient bit per stage
	localparam int NW = 32 + FRAC_BITS;
	localparam int ND = NW + 4;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [NW-1:0] quo;
	} dv_t;

	typedef struct packed {
		dv_t [2:0] d;
		logic [32:0] den;
		logic [2:0] neg;
		logic signed [31:0] px, py, pz;
		logic wz;
	} st_t;

	logic [ND-1:0] v_q;
	st_t st_q [NW+1];
	logic adv;
	assign adv = !v_q[ND-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_q[ND-1];

	logic signed [31:0] pv [3];
	assign pv[0] = pin.px;
	assign pv[1] = pin.py;
	assign pv[2] = pin.pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[ND-2:0], in_valid};
	end

	// stage 0 takes magnitudes; then restoring division, one bit per stage
	// (rem in quo shifts left)
	always_ff @(posedge clk) begin
		st_t nx;
		logic [NW:0] tr;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				st_q[0].d[k].rem <= '0;
				st_q[0].d[k].quo <= NW'(pv[k][31] ? -{{FRAC_BITS{1'b1}}, pv[k]}
					: {{FRAC_BITS{1'b0}}, pv[k]}) << FRAC_BITS;
				st_q[0].neg[k] <= pv[k][31] ^ pin.w[31];
			end
			st_q[0].den <= pin.w[31] ? -{1'b1, pin.w} : {1'b0, pin.w};
			st_q[0].px <= pin.px;
			st_q[0].py <= pin.py;
			st_q[0].pz <= pin.pz;
			st_q[0].wz <= pin.w == '0;
			for (int g = 1; g <= NW; g++) begin
				nx = st_q[g-1];
				for (int k = 0; k < 3; k++) begin
					tr = {st_q[g-1].d[k].rem, st_q[g-1].d[k].quo[NW-1]};
					if (tr >= {{(NW-32){1'b0}}, st_q[g-1].den}) begin
						nx.d[k].rem = NW'(tr - {{(NW-32){1'b0}}, st_q[g-1].den});
						nx.d[k].quo = {st_q[g-1].d[k].quo[NW-2:0], 1'b1};
					end else begin
						nx.d[k].rem = tr[NW-1:0];
						nx.d[k].quo = {st_q[g-1].d[k].quo[NW-2:0], 1'b0};
					end
				end
				st_q[g] <= nx;
			end
		end
	end

	// signed saturated quotients, or pass-through on zero w
	logic signed [31:0] qv [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [NW+1:0] s;
			s = st_q[NW].neg[k] ? -$signed({2'b00, st_q[NW].d[k].quo})
				: $signed({2'b00, st_q[NW].d[k].quo});
			qv[k] = vrp_pkg::sat32(96'(s));
		end
		if (st_q[NW].wz) begin
			qv[0] = st_q[NW].px;
			qv[1] = st_q[NW].py;
			qv[2] = st_q[NW].pz;
		end
	end

	logic signed [31:0] qx_a, qy_a, qz_a, qz_b, qz_c;
	logic wz_a, wz_b, wz_c;
	logic signed [64:0] mx_b, my_b;
	logic signed [31:0] sxo_c, syo_c;
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_a <= qv[0];
			qy_a <= qv[1];
			qz_a <= qv[2];
			wz_a <= st_q[NW].wz;
			mx_b <= (33'(qx_a) + (33'sd1 <<< FRAC_BITS)) * $signed({1'b0, cfg.screen_x_scale});
			my_b <= (33'(qy_a) + (33'sd1 <<< FRAC_BITS)) * $signed({1'b0, cfg.screen_y_scale});
			qz_b <= qz_a;
			wz_b <= wz_a;
			sxo_c <= vrp_pkg::sat32(96'(mx_b >>> FRAC_BITS));
			syo_c <= vrp_pkg::sat32(96'(my_b >>> FRAC_BITS));
			qz_c <= qz_b;
			wz_c <= wz_b;
		end
	end

	assign pout = '{screen_x: sxo_c, screen_y: syo_c, depth_out: qz_c, w_zero: wz_c};
endmodule

>>> rtl/core/vertex_rotate_project_top.sv
//------------------------------------------------------------------------------
// vertex_rotate_project_top
// Rotates, projects and maps one vertex to screen coordinates.
//------------------------------------------------------------------------------
// Accepts one vertex per cycle while the output is not stalled. The path runs through
// rotation and projection, a two-entry queue, then the pipelined divider (one
// quotient bit per stage, three quotients side by side) and screen mapping.
// Write registers over APB only while the block is idle.
module vertex_rotate_project_top #(
	parameter int FRAC_BITS = vrp_pkg::FracBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [vrp_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	vrp_if.sink vin,
	vrp_if.source pout
);
	vrp_pkg::cfg_t cfg_q;
	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_angle <= 18'sd65536;
			cfg_q.sin_angle <= '0;
			cfg_q.x_proj_scale <= 31'd65536;
			cfg_q.y_proj_scale <= 31'd65536;
			cfg_q.depth_scale <= 31'd65543;
			cfg_q.depth_bias <= -32'sd655;
			cfg_q.screen_x_scale <= 31'd17825792;
			cfg_q.screen_y_scale <= 31'd10485760;
		end else if (wr) begin
			unique case (paddr)
				vrp_pkg::RegCos:  cfg_q.cos_angle <= pwdata[17:0];
				vrp_pkg::RegSin:  cfg_q.sin_angle <= pwdata[17:0];
				vrp_pkg::RegAx:   cfg_q.x_proj_scale <= pwdata[30:0];
				vrp_pkg::RegAy:   cfg_q.y_proj_scale <= pwdata[30:0];
				vrp_pkg::RegQ:    cfg_q.depth_scale <= pwdata[30:0];
				vrp_pkg::RegBias: cfg_q.depth_bias <= pwdata;
				vrp_pkg::RegSx:   cfg_q.screen_x_scale <= pwdata[30:0];
				vrp_pkg::RegSy:   cfg_q.screen_y_scale <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			vrp_pkg::RegCos:  prdata = 32'($signed(cfg_q.cos_angle));
			vrp_pkg::RegSin:  prdata = 32'($signed(cfg_q.sin_angle));
			vrp_pkg::RegAx:   prdata = {1'b0, cfg_q.x_proj_scale};
			vrp_pkg::RegAy:   prdata = {1'b0, cfg_q.y_proj_scale};
			vrp_pkg::RegQ:    prdata = {1'b0, cfg_q.depth_scale};
			vrp_pkg::RegBias: prdata = cfg_q.depth_bias;
			vrp_pkg::RegSx:   prdata = {1'b0, cfg_q.screen_x_scale};
			vrp_pkg::RegSy:   prdata = {1'b0, cfg_q.screen_y_scale};
			default:          prdata = '0;
		endcase
	end

	logic f_valid, f_ready, b_valid, b_ready;
	vrp_pkg::proj_t f_data, b_data;

	vrp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(vin.valid), .in_ready(vin.ready), .vin(vin.payload),
		.out_valid(f_valid), .out_ready(f_ready), .pout(f_data)
	);

	vrp_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .din(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .dout(b_data)
	);

	vrp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(b_valid), .in_ready(b_ready), .pin(b_data),
		.out_valid(pout.valid), .out_ready(pout.ready), .pout(pout.payload)
	);
endmodule
